// ===== hw/rtl/ptsp_pkg.sv =====
// ptsp_pkg: shared constants, types and the pixel packing function
// for the planar tile sheet converter; no dependencies
`timescale 1ns / 1ps

package ptsp_pkg;

  localparam int unsigned SheetCount         = 223;
  localparam int unsigned SheetBytesTwoBpp   = 2048;
  localparam int unsigned SheetBytesThreeBpp = 1536;
  localparam int unsigned DecodedBytesTwoBpp = 1024;
  localparam int unsigned TileBytesTwoBpp    = 16;
  localparam int unsigned TileBytesThreeBpp  = 24;
  localparam int unsigned PairBytes          = 16;
  localparam int unsigned QueueDepth         = 2;

  localparam int unsigned PosW   = 11;
  localparam int unsigned SheetW = 8;
  localparam int unsigned TileW  = 6;
  localparam int unsigned OffW   = 5;
  localparam int unsigned LineW  = 3;
  localparam int unsigned AddrW  = 19;
  localparam int unsigned PixW   = 32;
  localparam int unsigned QCntW  = $clog2(QueueDepth + 1);
  localparam int unsigned QPtrW  = $clog2(QueueDepth);

  typedef logic [7:0]        byte_t;
  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [PixW-1:0]   pix_t;

  // one tile line waiting to be packed
  typedef struct packed {
    addr_t address;
    byte_t plane0;
    byte_t plane1;
    byte_t plane2;
  } line_t;

  // queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // eight pixels, leftmost from bit 7, high nibble first
  function automatic pix_t pack_line(byte_t p0, byte_t p1, byte_t p2);
    pix_t acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      acc[4*k +: 4] = {1'b0, p2[k], p1[k], p0[k]};
    end
    return acc;
  endfunction

endpackage

// ===== hw/rtl/ptsp_if.sv =====
// ptsp_if: valid/ready channel interfaces for sheet bytes and packed words
// depends on ptsp_pkg
`timescale 1ns / 1ps

interface ptsp_in_if import ptsp_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t sheet_byte;
  logic  three_bpp;

  modport source (output valid, output sheet_byte, output three_bpp, input ready);
  modport sink   (input valid, input sheet_byte, input three_bpp, output ready);
endinterface

interface ptsp_out_if import ptsp_pkg::*; ();
  logic  valid;
  logic  ready;
  addr_t out_address;
  pix_t  out_pixels;

  modport source (output valid, output out_address, output out_pixels, input ready);
  modport sink   (input valid, input out_address, input out_pixels, output ready);
endinterface

// ===== hw/rtl/ptsp_front.sv =====
// ptsp_front: byte intake, sheet/tile position tracking, plane pair buffer
// and line classification; depends on ptsp_pkg
`timescale 1ns / 1ps

module ptsp_front import ptsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  byte_t     sheet_byte_i,
  input  logic      three_bpp_i,
  input  q_status_t q_status_i,
  output logic      push_o,
  output line_t     push_line_o
);

  logic [PosW-1:0]   pos_q, pos_d;
  logic [SheetW-1:0] sheet_q, sheet_d;
  logic [TileW-1:0]  tile_q, tile_d;
  logic [OffW-1:0]   off_q, off_d;
  logic              mode_q, mode_d;
  logic [LineW-1:0]  rd_line_q, rd_line_d;
  byte_t             prev_q;
  byte_t             rd0_q, rd1_q;
  byte_t             pair_mem [PairBytes];

  logic             accept, mode, last, off_wrap, emit, mem_we;
  logic [LineW-1:0] line;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    mode     = (pos_q == '0) ? three_bpp_i : mode_q;
    last     = mode ? (pos_q == PosW'(SheetBytesThreeBpp - 1))
                    : (pos_q == PosW'(SheetBytesTwoBpp - 1));
    off_wrap = mode ? (off_q == OffW'(TileBytesThreeBpp - 1))
                    : (off_q == OffW'(TileBytesTwoBpp - 1));
    emit      = 1'b0;
    mem_we    = 1'b0;
    line      = '0;
    rd_line_d = rd_line_q;
    push_line_o.address = '0;
    push_line_o.plane0  = rd0_q;
    push_line_o.plane1  = rd1_q;
    push_line_o.plane2  = sheet_byte_i;
    if (mode) begin
      if (off_q < OffW'(PairBytes)) begin
        mem_we    = 1'b1;
        rd_line_d = '0;
      end else begin
        emit      = 1'b1;
        line      = off_q[LineW-1:0];
        rd_line_d = off_q[LineW-1:0] + LineW'(1);
      end
    end else begin
      // second half of a 2bpp sheet is dropped
      if (pos_q < PosW'(DecodedBytesTwoBpp) && off_q[0]) begin
        emit = 1'b1;
        line = off_q[LineW:1];
        push_line_o.plane0 = prev_q;
        push_line_o.plane1 = sheet_byte_i;
        push_line_o.plane2 = '0;
      end
    end
    push_line_o.address = {sheet_q, tile_q[5:4], line, tile_q[3:0], 2'b00};
    push_o = accept && emit;

    pos_d   = pos_q;
    sheet_d = sheet_q;
    tile_d  = tile_q;
    off_d   = off_q;
    mode_d  = mode_q;
    if (accept) begin
      mode_d = mode;
      if (last) begin
        pos_d  = '0;
        tile_d = '0;
        off_d  = '0;
        sheet_d = (sheet_q == SheetW'(SheetCount - 1)) ? '0 : sheet_q + SheetW'(1);
      end else begin
        pos_d = pos_q + PosW'(1);
        if (off_wrap) begin
          off_d  = '0;
          tile_d = tile_q + TileW'(1);
        end else begin
          off_d = off_q + OffW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      sheet_q   <= '0;
      tile_q    <= '0;
      off_q     <= '0;
      mode_q    <= 1'b0;
      rd_line_q <= '0;
    end else begin
      pos_q     <= pos_d;
      sheet_q   <= sheet_d;
      tile_q    <= tile_d;
      off_q     <= off_d;
      mode_q    <= mode_d;
      if (accept) begin
        rd_line_q <= rd_line_d;
      end
    end
  end

  // plane pair store, read data registered one byte ahead of use
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_q <= sheet_byte_i;
      rd0_q  <= pair_mem[{rd_line_d, 1'b0}];
      rd1_q  <= pair_mem[{rd_line_d, 1'b1}];
      if (mem_we) begin
        pair_mem[off_q[3:0]] <= sheet_byte_i;
      end
    end
  end

endmodule

// ===== hw/rtl/ptsp_fifo.sv =====
// ptsp_fifo: short queue of tile lines between front and back end
// depends on ptsp_pkg
`timescale 1ns / 1ps

module ptsp_fifo import ptsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  line_t     push_line_i,
  input  logic      pop_i,
  output line_t     pop_line_o,
  output q_status_t status_o
);

  line_t            entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == QCntW'(QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign pop_line_o = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= push_line_i;
    end
  end

endmodule

// ===== hw/rtl/ptsp_back.sv =====
// ptsp_back: packs queued tile lines into 4-bit pixels and holds the
// result word in the output register; depends on ptsp_pkg
`timescale 1ns / 1ps

module ptsp_back import ptsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t q_status_i,
  input  line_t     line_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output addr_t     out_address_o,
  output pix_t      out_pixels_o
);

  logic  valid_q;
  addr_t addr_q;
  pix_t  pix_q;
  logic  can_load;

  assign can_load      = !valid_q || out_ready_i;
  assign pop_o         = can_load && !q_status_i.empty;
  assign out_valid_o   = valid_q;
  assign out_address_o = addr_q;
  assign out_pixels_o  = pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load) begin
      valid_q <= !q_status_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      addr_q <= line_i.address;
      pix_q  <= pack_line(line_i.plane0, line_i.plane1, line_i.plane2);
    end
  end

endmodule

// ===== hw/rtl/planar_tile_sheet_to_packed_pixels.sv =====
// planar_tile_sheet_to_packed_pixels: top level, planar tile sheet bytes in,
// packed 4bpp words out; depends on ptsp_pkg, ptsp_if, ptsp_front, ptsp_fifo, ptsp_back
`timescale 1ns / 1ps

// Takes one decompressed sheet byte per word and, whenever a tile line is
// complete, delivers one word holding that line's four packed 4bpp bytes and
// the byte address of the first of them (sheet*2048 + tile row*512 + line*64
// + tile column*4). three_bpp is sampled on the first byte of each sheet only;
// a 3bpp sheet is 1536 bytes of 24-byte tiles, a 2bpp sheet is 2048 bytes of
// which only the first 1024 are decoded. The sheet index wraps after the last
// sheet. One byte is taken every cycle while the line queue is not full; a
// result passes through the line queue and then the output register. The
// two-entry line queue lets the input keep flowing while the output is
// stalled, and stalls the input once it fills. No clearing pass after reset.

module planar_tile_sheet_to_packed_pixels import ptsp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ptsp_in_if.sink    in_i,
  ptsp_out_if.source out_o
);

  // front to queue
  logic      push;
  line_t     push_line;
  // queue to back
  logic      pop;
  line_t     pop_line;
  q_status_t q_status;

  // front: position tracking and plane pair buffer
  ptsp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .sheet_byte_i (in_i.sheet_byte),
    .three_bpp_i  (in_i.three_bpp),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_line_o  (push_line)
  );

  // decoupling queue
  ptsp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_line_i (push_line),
    .pop_i       (pop),
    .pop_line_o  (pop_line),
    .status_o    (q_status)
  );

  // back: pixel packing and output register
  ptsp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_status_i    (q_status),
    .line_i        (pop_line),
    .pop_o         (pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_address_o (out_o.out_address),
    .out_pixels_o  (out_o.out_pixels)
  );

endmodule
